FILE: sv/selective_repeat_arq_engine_core_assert.svh
// Assertion macros for the selective-repeat ARQ engine.
`ifndef SELECTIVE_REPEAT_ARQ_ENGINE_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_ARQ_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`else
`define SRA_ASSERT(label, clk, rstn, prop)
`endif
`ifndef SYNTHESIS
`define SRA_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SRA_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: sv/sra_pkg.sv
// Package with types and constants of the selective-repeat ARQ engine.
package sra_pkg;
  localparam int unsigned SeqW = 6;
  localparam int unsigned SlotW = 5;
  localparam logic [5:0] SeqMax = 6'd63;
  localparam logic [5:0] Window = 6'd32;
  localparam logic [5:0] OutstandingMax = 6'd63;

  localparam logic [2:0] FuncPkt = 3'd0;
  localparam logic [2:0] FuncPhy = 3'd1;
  localparam logic [2:0] FuncFrame = 3'd2;
  localparam logic [2:0] FuncDataTo = 3'd3;
  localparam logic [2:0] FuncAckTo = 3'd4;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindNak = 2'd2;

  localparam logic [2:0] ActData = 3'd0;
  localparam logic [2:0] ActAck = 3'd1;
  localparam logic [2:0] ActNak = 3'd2;
  localparam logic [2:0] ActStore = 3'd3;
  localparam logic [2:0] ActDeliver = 3'd4;
  localparam logic [2:0] ActStatus = 3'd5;

  typedef enum logic [3:0] {
    StIdle, StDecode, StNak, StResend, StStore, StDeliver, StRelease, StStatus, StWait
  } state_e;

  typedef struct packed {
    logic load;
    logic [2:0] emit_act;
    logic emit;
    logic do_pkt;
    logic do_phy;
    logic do_store;
    logic do_deliver;
    logic do_release;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic good;
    logic [1:0] kind;
    logic need_nak;
    logic can_resend;
    logic can_store;
    logic deliver_ok;
    logic release_ok;
    logic out_busy;
  } sts_t;

  function automatic logic [5:0] seq_next(input logic [5:0] k);
    seq_next = (k < SeqMax) ? k + 6'd1 : 6'd0;
  endfunction

  function automatic logic in_window(input logic [5:0] a, input logic [5:0] b,
                                     input logic [5:0] c);
    in_window = (a <= b && b < c) || (c < a && b < c) || (c < a && a <= b);
  endfunction
endpackage

FILE: sv/sra_ctrl.sv
// Controller state machine that sequences the result items of one event.
module sra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sra_pkg::sts_t     sts_i,
  output sra_pkg::cmd_t     cmd_o
);
  sra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sra_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sra_pkg::StIdle: if (in_valid_i) state_d = sra_pkg::StDecode;
      sra_pkg::StDecode: begin
        if (sts_i.func == sra_pkg::FuncFrame) begin
          if (sts_i.need_nak) state_d = sra_pkg::StNak;
          else if (!sts_i.good) state_d = sra_pkg::StStatus;
          else if (sts_i.kind == sra_pkg::KindData) state_d = sra_pkg::StStore;
          else if (sts_i.kind == sra_pkg::KindNak) state_d = sra_pkg::StResend;
          else state_d = sra_pkg::StRelease;
        end else if (sts_i.func == sra_pkg::FuncPkt || sts_i.func == sra_pkg::FuncDataTo ||
                     sts_i.func == sra_pkg::FuncAckTo) begin
          if (!sts_i.out_busy) state_d = sra_pkg::StStatus;
        end else begin
          state_d = sra_pkg::StStatus;
        end
      end
      sra_pkg::StNak: if (!sts_i.out_busy) begin
        if (!sts_i.good) state_d = sra_pkg::StStatus;
        else state_d = sra_pkg::StStore;
      end
      sra_pkg::StResend: if (!sts_i.out_busy) state_d = sra_pkg::StRelease;
      sra_pkg::StStore: begin
        if (!sts_i.can_store) state_d = sra_pkg::StRelease;
        else if (!sts_i.out_busy) state_d = sra_pkg::StDeliver;
      end
      sra_pkg::StDeliver: begin
        if (!sts_i.deliver_ok) state_d = sra_pkg::StRelease;
      end
      sra_pkg::StRelease: if (!sts_i.release_ok) state_d = sra_pkg::StStatus;
      sra_pkg::StStatus: if (!sts_i.out_busy) state_d = sra_pkg::StWait;
      sra_pkg::StWait: state_d = sra_pkg::StIdle;
      default: state_d = sra_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == sra_pkg::StIdle);
    cmd_o.load = in_ready_o && in_valid_i;
    case (state_q)
      sra_pkg::StDecode: begin
        cmd_o.do_phy = (sts_i.func == sra_pkg::FuncPhy);
        if (!sts_i.out_busy) begin
          if (sts_i.func == sra_pkg::FuncPkt) begin
            cmd_o.emit = 1'b1; cmd_o.emit_act = sra_pkg::ActData; cmd_o.do_pkt = 1'b1;
          end else if (sts_i.func == sra_pkg::FuncDataTo) begin
            cmd_o.emit = 1'b1; cmd_o.emit_act = sra_pkg::ActData;
          end else if (sts_i.func == sra_pkg::FuncAckTo) begin
            cmd_o.emit = 1'b1; cmd_o.emit_act = sra_pkg::ActAck;
          end
        end
      end
      sra_pkg::StNak: begin
        cmd_o.emit = !sts_i.out_busy; cmd_o.emit_act = sra_pkg::ActNak;
      end
      sra_pkg::StResend: begin
        cmd_o.emit = !sts_i.out_busy && sts_i.can_resend; cmd_o.emit_act = sra_pkg::ActData;
      end
      sra_pkg::StStore: begin
        cmd_o.emit = !sts_i.out_busy && sts_i.can_store; cmd_o.emit_act = sra_pkg::ActStore;
        cmd_o.do_store = cmd_o.emit;
      end
      sra_pkg::StDeliver: begin
        cmd_o.emit = !sts_i.out_busy && sts_i.deliver_ok;
        cmd_o.emit_act = sra_pkg::ActDeliver; cmd_o.do_deliver = cmd_o.emit;
      end
      sra_pkg::StRelease: cmd_o.do_release = sts_i.release_ok;
      sra_pkg::StStatus: begin
        cmd_o.emit = !sts_i.out_busy; cmd_o.emit_act = sra_pkg::ActStatus;
      end
      default: ;
    endcase
  end
endmodule

FILE: sv/sra_dp.sv
// Datapath with the window state, the slot map and the result register.
module sra_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        func_i,
  input  logic              frame_good_i,
  input  logic [1:0]        frame_kind_i,
  input  logic [5:0]        frame_seq_i,
  input  logic [5:0]        frame_ack_i,
  input  logic [5:0]        timeout_seq_i,
  input  sra_pkg::cmd_t     cmd_i,
  output sra_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        action_o,
  output logic [5:0]        out_seq_o,
  output logic [5:0]        out_ack_o,
  output logic [4:0]        slot_o,
  output logic              start_data_timer_o,
  output logic              ack_timer_restart_o,
  output logic [5:0]        released_from_o,
  output logic [5:0]        released_count_o,
  output logic              network_enable_o,
  output logic              last_o
);
  logic [2:0] func_q;
  logic good_q;
  logic [1:0] kind_q;
  logic [5:0] fseq_q, fack_q, tseq_q;
  logic [5:0] send_base_q, send_base_d, next_send_q, next_send_d;
  logic [5:0] recv_base_q, recv_base_d, recv_limit_q, recv_limit_d;
  logic [5:0] outst_q, outst_d, rel_from_q, rel_cnt_q, rel_cnt_d;
  logic [31:0] filled_q, filled_d;
  logic nak_ok_q, nak_ok_d, phy_q, phy_d;
  logic ov_q;
  logic [2:0] act_q;
  logic [5:0] seq_q, ack_q, rf_q, rc_q;
  logic [4:0] slot_q;
  logic dt_q, at_q, ne_q, last_q;
  logic [5:0] resend_seq, emit_seq, piggy;

  assign piggy = recv_base_q + sra_pkg::SeqMax;
  assign resend_seq = sra_pkg::seq_next(fack_q);
  assign sts_o.func = func_q;
  assign sts_o.good = good_q;
  assign sts_o.kind = kind_q;
  assign sts_o.need_nak = nak_ok_q && (!good_q || (kind_q == sra_pkg::KindData &&
                          fseq_q != recv_base_q));
  assign sts_o.can_resend = sra_pkg::in_window(send_base_q, resend_seq, next_send_q);
  assign sts_o.can_store = sra_pkg::in_window(recv_base_q, fseq_q, recv_limit_q) &&
                           !filled_q[fseq_q[4:0]];
  assign sts_o.deliver_ok = filled_q[recv_base_q[4:0]];
  assign sts_o.release_ok = sra_pkg::in_window(send_base_q, fack_q, next_send_q);
  assign sts_o.out_busy = ov_q && !out_ready_i;

  always_comb begin
    send_base_d = send_base_q; next_send_d = next_send_q;
    recv_base_d = recv_base_q; recv_limit_d = recv_limit_q;
    outst_d = outst_q; rel_cnt_d = rel_cnt_q; filled_d = filled_q;
    nak_ok_d = nak_ok_q; phy_d = phy_q;
    if (cmd_i.load) rel_cnt_d = '0;
    if (cmd_i.do_phy) phy_d = 1'b1;
    if (cmd_i.emit && (cmd_i.emit_act == sra_pkg::ActData ||
        cmd_i.emit_act == sra_pkg::ActAck || cmd_i.emit_act == sra_pkg::ActNak)) begin
      phy_d = 1'b0;
    end
    if (cmd_i.emit && cmd_i.emit_act == sra_pkg::ActNak) nak_ok_d = 1'b0;
    if (cmd_i.do_pkt) begin
      if (outst_q < sra_pkg::OutstandingMax) outst_d = outst_q + 6'd1;
      next_send_d = sra_pkg::seq_next(next_send_q);
    end
    if (cmd_i.do_store) filled_d[fseq_q[4:0]] = 1'b1;
    if (cmd_i.do_deliver) begin
      filled_d[recv_base_q[4:0]] = 1'b0;
      nak_ok_d = 1'b1;
      recv_base_d = sra_pkg::seq_next(recv_base_q);
      recv_limit_d = sra_pkg::seq_next(recv_limit_q);
    end
    if (cmd_i.do_release) begin
      if (outst_q != 6'd0) outst_d = outst_q - 6'd1;
      rel_cnt_d = rel_cnt_q + 6'd1;
      send_base_d = sra_pkg::seq_next(send_base_q);
    end
  end

  always_comb begin
    case (func_q)
      sra_pkg::FuncPkt: emit_seq = next_send_q;
      sra_pkg::FuncDataTo: emit_seq = tseq_q;
      default: emit_seq = resend_seq;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_base_q <= '0; next_send_q <= '0; recv_base_q <= '0;
      recv_limit_q <= sra_pkg::Window; outst_q <= '0; filled_q <= '0;
      nak_ok_q <= 1'b1; phy_q <= 1'b0; ov_q <= 1'b0; rel_cnt_q <= '0;
      rel_from_q <= '0;
    end else begin
      send_base_q <= send_base_d; next_send_q <= next_send_d;
      recv_base_q <= recv_base_d; recv_limit_q <= recv_limit_d;
      outst_q <= outst_d; filled_q <= filled_d; nak_ok_q <= nak_ok_d;
      phy_q <= phy_d; rel_cnt_q <= rel_cnt_d;
      if (cmd_i.load) rel_from_q <= send_base_q;
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i; good_q <= frame_good_i; kind_q <= frame_kind_i;
      fseq_q <= frame_seq_i; fack_q <= frame_ack_i; tseq_q <= timeout_seq_i;
    end
    if (cmd_i.emit) begin
      act_q <= cmd_i.emit_act;
      seq_q <= '0; ack_q <= '0; slot_q <= '0; dt_q <= 1'b0; at_q <= 1'b0;
      rf_q <= '0; rc_q <= '0; ne_q <= 1'b0; last_q <= 1'b0;
      case (cmd_i.emit_act)
        sra_pkg::ActData: begin
          seq_q <= emit_seq; ack_q <= piggy; slot_q <= emit_seq[4:0]; dt_q <= 1'b1;
        end
        sra_pkg::ActAck, sra_pkg::ActNak: ack_q <= piggy;
        sra_pkg::ActStore: begin
          seq_q <= fseq_q; slot_q <= fseq_q[4:0];
        end
        sra_pkg::ActDeliver: begin
          seq_q <= recv_base_q; slot_q <= recv_base_q[4:0]; at_q <= 1'b1;
        end
        sra_pkg::ActStatus: begin
          rf_q <= rel_from_q; rc_q <= rel_cnt_q; last_q <= 1'b1;
          ne_q <= (outst_q < sra_pkg::Window) && phy_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign action_o = act_q;
  assign out_seq_o = seq_q;
  assign out_ack_o = ack_q;
  assign slot_o = slot_q;
  assign start_data_timer_o = dt_q;
  assign ack_timer_restart_o = at_q;
  assign released_from_o = rf_q;
  assign released_count_o = rc_q;
  assign network_enable_o = ne_q;
  assign last_o = last_q;
endmodule

FILE: sv/selective_repeat_arq_engine_core.sv
// Top level of the selective-repeat ARQ window engine.
//  channel  direction  handshake
//  in       input      in_valid_i / in_ready_o
//  out      output     out_valid_o / out_ready_i
// A control event passes through accept, decode, status and the return to idle.
// A frame adds a step for each of the NAK, resend and store steps, one per delivery
// and one per released frame plus one to end each walk.
// Reset clears all window state at once; no clearing pass is needed.
// A stalled output holds the controller in its current step while it has a result to emit.
`include "selective_repeat_arq_engine_core_assert.svh"
module selective_repeat_arq_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic       frame_good_i,
  input  logic [1:0] frame_kind_i,
  input  logic [5:0] frame_seq_i,
  input  logic [5:0] frame_ack_i,
  input  logic [5:0] timeout_seq_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] action_o,
  output logic [5:0] out_seq_o,
  output logic [5:0] out_ack_o,
  output logic [4:0] slot_o,
  output logic       start_data_timer_o,
  output logic       ack_timer_restart_o,
  output logic [5:0] released_from_o,
  output logic [5:0] released_count_o,
  output logic       network_enable_o,
  output logic       last_o
);
  sra_pkg::cmd_t cmd;
  sra_pkg::sts_t sts;

  sra_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  sra_dp u_dp (
    .clk_i, .rst_ni, .func_i, .frame_good_i, .frame_kind_i, .frame_seq_i,
    .frame_ack_i, .timeout_seq_i, .cmd_i(cmd), .sts_o(sts), .out_valid_o,
    .out_ready_i, .action_o, .out_seq_o, .out_ack_o, .slot_o, .start_data_timer_o,
    .ack_timer_restart_o, .released_from_o, .released_count_o, .network_enable_o,
    .last_o
  );

  `SRA_ASSERT(a_emit_not_busy, clk_i, rst_ni, cmd.emit |-> !sts.out_busy)
  `SRA_ASSERT(a_last_is_status, clk_i, rst_ni, out_valid_o && last_o |-> action_o == sra_pkg::ActStatus)
  `SRA_ASSERT(a_out_held, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_seq_o))
endmodule

FILE: dv/selective_repeat_arq_engine_core_checker.sv
// Checker that predicts and compares the result transfers of the ARQ window engine.
module selective_repeat_arq_engine_core_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] func_i,
  input  logic       frame_good_i,
  input  logic [1:0] frame_kind_i,
  input  logic [5:0] frame_seq_i,
  input  logic [5:0] frame_ack_i,
  input  logic [5:0] timeout_seq_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] action_i,
  input  logic [5:0] out_seq_i,
  input  logic [5:0] out_ack_i,
  input  logic [4:0] slot_i,
  input  logic       start_data_timer_i,
  input  logic       ack_timer_restart_i,
  input  logic [5:0] released_from_i,
  input  logic [5:0] released_count_i,
  input  logic       network_enable_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] seq;
    logic [5:0] ack;
    logic [4:0] slot;
    logic       dt;
    logic       at;
    logic [5:0] rel_from;
    logic [5:0] rel_count;
    logic       net_en;
    logic       last;
  } arq_result_t;

  arq_result_t result_q[$];
  logic [5:0]  tx_base, tx_next, rx_base, rx_limit, in_flight;
  logic [31:0] rx_filled;
  logic        nak_ok, phy_rdy;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic logic [5:0] wrap_inc(logic [5:0] k);
    return (k == sra_pkg::SeqMax) ? 6'd0 : k + 6'd1;
  endfunction

  function automatic logic between(logic [5:0] a, logic [5:0] b, logic [5:0] c);
    return (a <= b && b < c) || (c < a && b < c) || (c < a && a <= b);
  endfunction

  task automatic push_result(logic [2:0] act, logic [5:0] seq, logic [5:0] ack,
                             logic [4:0] slot, logic dt, logic at, logic [5:0] rf,
                             logic [5:0] rc, logic ne, logic lst);
    arq_result_t r;
    r = '{act, seq, ack, slot, dt, at, rf, rc, ne, lst};
    result_q.push_back(r);
  endtask

  task automatic push_data(logic [5:0] seq);
    push_result(sra_pkg::ActData, seq, rx_base - 6'd1, seq[4:0], 1'b1, 1'b0, '0, '0,
                1'b0, 1'b0);
    phy_rdy = 1'b0;
  endtask

  task automatic push_ctrl(logic [2:0] act);
    push_result(act, '0, rx_base - 6'd1, '0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    if (act == sra_pkg::ActNak) nak_ok = 1'b0;
    phy_rdy = 1'b0;
  endtask

  task automatic predict_event();
    logic [5:0] rf, rc, r;
    rf = tx_base;
    rc = '0;
    case (func_i)
      sra_pkg::FuncPkt: begin
        if (in_flight < sra_pkg::OutstandingMax) in_flight++;
        push_data(tx_next);
        tx_next = wrap_inc(tx_next);
      end
      sra_pkg::FuncPhy: phy_rdy = 1'b1;
      sra_pkg::FuncFrame: begin
        if (!frame_good_i) begin
          if (nak_ok) push_ctrl(sra_pkg::ActNak);
        end else begin
          if (frame_kind_i == sra_pkg::KindData) begin
            if (frame_seq_i != rx_base && nak_ok) push_ctrl(sra_pkg::ActNak);
            if (between(rx_base, frame_seq_i, rx_limit) && !rx_filled[frame_seq_i[4:0]]) begin
              rx_filled[frame_seq_i[4:0]] = 1'b1;
              push_result(sra_pkg::ActStore, frame_seq_i, '0, frame_seq_i[4:0], 1'b0, 1'b0,
                          '0, '0, 1'b0, 1'b0);
              while (rx_filled[rx_base[4:0]]) begin
                push_result(sra_pkg::ActDeliver, rx_base, '0, rx_base[4:0], 1'b0, 1'b1,
                            '0, '0, 1'b0, 1'b0);
                rx_filled[rx_base[4:0]] = 1'b0;
                nak_ok = 1'b1;
                rx_base = wrap_inc(rx_base);
                rx_limit = wrap_inc(rx_limit);
              end
            end
          end else if (frame_kind_i == sra_pkg::KindNak) begin
            r = wrap_inc(frame_ack_i);
            if (between(tx_base, r, tx_next)) push_data(r);
          end
          while (between(tx_base, frame_ack_i, tx_next)) begin
            if (in_flight > 6'd0) in_flight--;
            rc++;
            tx_base = wrap_inc(tx_base);
          end
        end
      end
      sra_pkg::FuncDataTo: push_data(timeout_seq_i);
      sra_pkg::FuncAckTo: push_ctrl(sra_pkg::ActAck);
      default: ;
    endcase
    push_result(sra_pkg::ActStatus, '0, '0, '0, 1'b0, 1'b0, rf, rc,
                (in_flight < sra_pkg::Window) && phy_rdy, 1'b1);
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    arq_result_t e;
    if (!rst_ni) begin
      tx_base = '0; tx_next = '0; rx_base = '0; rx_limit = sra_pkg::Window; in_flight = '0;
      rx_filled = '0; nak_ok = 1'b1; phy_rdy = 1'b0; fails = 0;
      result_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          e = result_q.pop_front();
          compare_field("action", e.action, action_i);
          compare_field("out_seq", e.seq, out_seq_i);
          compare_field("out_ack", e.ack, out_ack_i);
          compare_field("slot", e.slot, slot_i);
          compare_field("start_data_timer", e.dt, start_data_timer_i);
          compare_field("ack_timer_restart", e.at, ack_timer_restart_i);
          compare_field("released_from", e.rel_from, released_from_i);
          compare_field("released_count", e.rel_count, released_count_i);
          compare_field("network_enable", e.net_en, network_enable_i);
          compare_field("last", e.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_event();
    end
  end
endmodule

FILE: dv/selective_repeat_arq_engine_core_tb.sv
// Testbench top that drives events into the ARQ window engine and gives the verdict.
module selective_repeat_arq_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] func_i, action_o;
  logic frame_good_i;
  logic [1:0] frame_kind_i;
  logic [5:0] frame_seq_i, frame_ack_i, timeout_seq_i;
  logic [5:0] out_seq_o, out_ack_o, released_from_o, released_count_o;
  logic [4:0] slot_o;
  logic start_data_timer_o, ack_timer_restart_o, network_enable_o, last_o;
  int fail_count, pending;

  selective_repeat_arq_engine_core DUT (.*);

  selective_repeat_arq_engine_core_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .frame_good_i,
    .frame_kind_i, .frame_seq_i, .frame_ack_i, .timeout_seq_i,
    .out_valid_i(out_valid_o), .out_ready_i, .action_i(action_o), .out_seq_i(out_seq_o),
    .out_ack_i(out_ack_o), .slot_i(slot_o), .start_data_timer_i(start_data_timer_o),
    .ack_timer_restart_i(ack_timer_restart_o), .released_from_i(released_from_o),
    .released_count_i(released_count_o), .network_enable_i(network_enable_o),
    .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("selective_repeat_arq_engine_core_tb NOT OK");
    $finish;
  end

  // Our own copy of the sender's position so that acks and timeouts mostly hit the window.
  logic [5:0] sent_hi, recv_hi;

  task automatic send_event(logic [2:0] f, logic g, logic [1:0] k, logic [5:0] s,
                            logic [5:0] a, logic [5:0] t, bit do_gap);
    int gap;
    gap = do_gap ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    frame_good_i  <= g;
    frame_kind_i  <= k;
    frame_seq_i   <= s;
    frame_ack_i   <= a;
    timeout_seq_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    if (f == sra_pkg::FuncPkt) sent_hi = sent_hi + 6'd1;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  initial begin
    int hold;
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, 17);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int n, mode, cnt;
    logic [5:0] r;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0; func_i = '0;
    frame_good_i = 1'b0; frame_kind_i = '0; frame_seq_i = '0; frame_ack_i = '0;
    timeout_seq_i = '0; sent_hi = '0; recv_hi = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_event(sra_pkg::FuncPhy, '0, '0, '0, '0, '0, 1'b1);
    send_event(sra_pkg::FuncPkt, '0, '0, '0, '0, '0, 1'b1);
    send_event(sra_pkg::FuncPkt, '0, '0, '0, '0, '0, 1'b0);
    send_event(sra_pkg::FuncFrame, 1'b0, sra_pkg::KindData, 6'd63, 6'd63, 6'd63, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindData, 6'd2, 6'd63, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindData, 6'd2, 6'd63, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindData, 6'd40, 6'd63, '0, 1'b0);
    send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindData, 6'd0, 6'd63, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindData, 6'd1, 6'd0, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindNak, '0, '0, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, 2'd3, '0, 6'd1, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, 2'd1, '0, 6'd1, '0, 1'b1);
    send_event(sra_pkg::FuncDataTo, '0, '0, '0, '0, 6'd63, 1'b1);
    send_event(sra_pkg::FuncAckTo, '0, '0, '0, '0, '0, 1'b1);
    for (int f = 5; f < 8; f++) send_event(3'(f), 1'b1, 2'd3, 6'd63, 6'd63, 6'd63, 1'b0);
    for (int i = 0; i < 34; i++) send_event(sra_pkg::FuncPkt, '0, '0, '0, '0, '0, i < 3);
    send_event(sra_pkg::FuncPhy, '0, '0, '0, '0, '0, 1'b1);
    send_event(sra_pkg::FuncFrame, 1'b1, 2'd1, '0, sent_hi - 6'd1, '0, 1'b1);
    drain();
    repeat (80) @(posedge clk_i);
    n = 0;
    while (n < 150) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        cnt = $urandom_range(1, 40);
        for (int i = 0; i < cnt; i++) begin
          r = recv_hi + 6'($urandom_range(0, 34));
          send_event(sra_pkg::FuncFrame, 1'b1, sra_pkg::KindData,
                     ($urandom_range(0, 9) < 7) ? recv_hi : r,
                     sent_hi - 6'($urandom_range(0, 40)), '0, $urandom_range(0, 3) != 0);
          recv_hi = recv_hi + 6'd1;
          n++;
        end
      end else if (mode < 4) begin
        send_event(sra_pkg::FuncPkt, '0, '0, '0, '0, '0, $urandom_range(0, 2) != 0);
        n++;
      end else if (mode < 6) begin
        send_event(sra_pkg::FuncFrame, 1'b1, 2'($urandom_range(1, 3)), 6'($urandom),
                   sent_hi - 6'($urandom_range(0, 36)), 6'($urandom), 1'b1);
        n++;
      end else if (mode == 6) begin
        send_event(sra_pkg::FuncPhy, '0, '0, '0, '0, '0, 1'b1);
        n++;
      end else if (mode == 7) begin
        send_event(sra_pkg::FuncDataTo, 1'($urandom), 2'($urandom), 6'($urandom),
                   6'($urandom), sent_hi - 6'($urandom_range(1, 33)), 1'b1);
        n++;
      end else if (mode == 8) begin
        send_event(3'($urandom_range(0, 7)), 1'($urandom), 2'($urandom), 6'($urandom),
                   6'($urandom), 6'($urandom), 1'b1);
        n++;
      end else begin
        send_event(sra_pkg::FuncAckTo, '0, '0, '0, '0, '0, 1'b1);
        n++;
      end
      if (n == 100) drain();
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("selective_repeat_arq_engine_core_tb OK");
    else $display("selective_repeat_arq_engine_core_tb NOT OK");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/sra_pkg.sv
sv/sra_ctrl.sv
sv/sra_dp.sv
sv/selective_repeat_arq_engine_core.sv
dv/selective_repeat_arq_engine_core_checker.sv
dv/selective_repeat_arq_engine_core_tb.sv
